// ===== rtl/pc_speaker_tone_mixer_macros.svh =====
// Assertion macros shared by the tone mixer RTL.
`ifndef PC_SPEAKER_TONE_MIXER_MACROS_SVH
`define PC_SPEAKER_TONE_MIXER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define PCSTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pc_speaker_tone_mixer: check failed");
// Checked at every edge, reset included.
`define PCSTM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("pc_speaker_tone_mixer: check failed");
`else
`define PCSTM_ASSERT(lbl, prop)
`define PCSTM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/pcstm_pkg.sv =====
`default_nettype none

package pcstm_pkg;

    localparam int TONE_DEPTH = 64;
    localparam int NUM_TONES  = 96;

    localparam int PTR_W      = $clog2(TONE_DEPTH);
    localparam int CNT_W      = $clog2(TONE_DEPTH + 1);

    localparam int HZ_W          = 12;
    localparam int HZ_TABLE_SIZE = 96;
    localparam int HZ_IDX_W      = $clog2(HZ_TABLE_SIZE);

    localparam int RATE_W   = 17;
    localparam int PERIOD_W = 10;
    localparam int AMP_W    = 15;
    localparam int PHASE_W  = 32;
    localparam int SLEFT_W  = 17;

    // Serial arithmetic unit: multiplier digit count and dividend length.
    localparam int MULB_W   = HZ_W;
    localparam int MULB_IW  = $clog2(MULB_W);
    localparam int DIVD_W   = PHASE_W + HZ_W + 1;
    localparam int STEP_W   = $clog2(DIVD_W);
    localparam int REM_W    = RATE_W;

    localparam logic [REM_W-1:0]   MS_PER_SEC  = REM_W'(1000);
    localparam logic [SLEFT_W-1:0] SAMPLES_MAX = {SLEFT_W{1'b1}};

    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(44100);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(7);
    localparam logic [AMP_W-1:0]    AMP_RESET    = AMP_W'(8192);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_MIX  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_TONE_PERIOD = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_RS_MUL,
        ST_RS_DIV,
        ST_LEN_MUL,
        ST_LEN_DIV,
        ST_WV_MUL,
        ST_WV_DIV,
        ST_MIX
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic out_free;
        logic mix_fire;
        logic mul_last;
        logic div_last;
    } ctrl_t;

    localparam logic [HZ_W-1:0] HZ_TABLE [HZ_TABLE_SIZE] = '{
        12'd0,    12'd175,  12'd180,  12'd185,  12'd190,  12'd196,  12'd202,  12'd208,
        12'd214,  12'd220,  12'd226,  12'd233,  12'd240,  12'd247,  12'd254,  12'd262,
        12'd269,  12'd277,  12'd285,  12'd294,  12'd302,  12'd311,  12'd320,  12'd330,
        12'd339,  12'd349,  12'd359,  12'd370,  12'd381,  12'd392,  12'd403,  12'd415,
        12'd427,  12'd440,  12'd453,  12'd466,  12'd480,  12'd494,  12'd508,  12'd523,
        12'd539,  12'd554,  12'd571,  12'd587,  12'd604,  12'd622,  12'd640,  12'd659,
        12'd679,  12'd698,  12'd719,  12'd740,  12'd762,  12'd784,  12'd807,  12'd831,
        12'd855,  12'd880,  12'd906,  12'd932,  12'd960,  12'd988,  12'd1017, 12'd1046,
        12'd1077, 12'd1109, 12'd1141, 12'd1175, 12'd1210, 12'd1244, 12'd1281, 12'd1318,
        12'd1357, 12'd1397, 12'd1439, 12'd1480, 12'd1523, 12'd1569, 12'd1614, 12'd1661,
        12'd1711, 12'd1762, 12'd1813, 12'd1864, 12'd1921, 12'd1975, 12'd2036, 12'd2093,
        12'd2157, 12'd2217, 12'd2285, 12'd2353, 12'd2420, 12'd2490, 12'd2565, 12'd2639
    };

    // Silent for codes past the table or past the configured tone count.
    function automatic logic [HZ_W-1:0] code_to_hz(input logic [7:0] code);
        logic [HZ_W-1:0] hz;
        hz = '0;
        if (({1'b0, code} < 9'(NUM_TONES)) && ({1'b0, code} < 9'(HZ_TABLE_SIZE))) begin
            hz = HZ_TABLE[code[HZ_IDX_W-1:0]];
        end
        return hz;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [16:0] v);
        logic [15:0] r;
        if (v[16] != v[15]) begin
            r = v[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pc_speaker_tone_mixer.sv =====
// PC speaker tone mixer.
// Input channel s_*: one beat carries an opcode. Push queues a tone code (dropped
// when the 64-deep queue is full), stop empties the queue, mix adds the square
// wave to s_left_in/s_right_in and returns one beat on m_*; no-op does nothing.
// Push, stop and no-op return no beat.
// A mix runs on a shared bit-serial multiply/divide unit, one bit per cycle:
// a silent sample goes straight to the mix, a sample within a tone takes one
// pass (12 multiply steps, 45 divide steps), and a sample that starts a new tone
// takes up to three (phase rescale and tone length add two more passes). The
// divider length sets the divide step count.
// Results sit in an output register; the block takes the next beat while one
// waits, but a following mix holds in its last cycle until the slot frees, so
// a stalled receiver loses nothing. Configuration goes through the APB port at
// 0x0 sample_rate, 0x4 tone_period_ms, 0x8 amplitude, written while idle.
// Synchronous reset (aresetn low) empties the queue, silences the tone, zeroes
// the phase and reloads the register defaults; queue storage is not cleared.
`default_nettype none

`include "pc_speaker_tone_mixer_macros.svh"

module pc_speaker_tone_mixer
    import pcstm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [7:0]         s_tone_code,
    input  wire logic signed [15:0] s_left_in,
    input  wire logic signed [15:0] s_right_in,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_left_out,
    output logic signed [15:0]      m_right_out,
    output logic                    m_playing,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Configuration registers.
    logic [RATE_W-1:0]   sample_rate_reg;
    logic [PERIOD_W-1:0] tone_period_reg;
    logic [AMP_W-1:0]    amplitude_reg;

    // Tone queue.
    logic [7:0]          tone_mem [TONE_DEPTH];
    logic [7:0]          rd_data_reg;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    tail_reg;
    logic [CNT_W-1:0]    tone_count_reg;

    // Tone generator state.
    logic [HZ_W-1:0]     current_hz_reg;
    logic [HZ_W-1:0]     old_hz_reg;
    logic [SLEFT_W-1:0]  samples_left_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic                wave_neg_reg;

    // Serial multiply/divide unit.
    logic [DIVD_W-1:0]   work_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;

    // Sample held through the computation.
    logic signed [15:0]  left_hold_reg;
    logic signed [15:0]  right_hold_reg;

    // Output slot.
    logic                m_valid_reg;
    logic signed [15:0]  left_out_reg;
    logic signed [15:0]  right_out_reg;
    logic                playing_reg;

    state_t              state_reg;
    state_t              state_next;
    ctrl_t               ctrl;

    logic                s_accept;
    logic                cfg_write;
    logic                push_ok;
    logic [HZ_W-1:0]     pop_hz;
    logic [PHASE_W-1:0]  mul_a;
    logic [MULB_W-1:0]   mul_b;
    logic                mul_bit;
    logic [DIVD_W-1:0]   mul_next;
    logic [REM_W-1:0]    divisor;
    logic [REM_W:0]      div_trial;
    logic                div_ge;
    logic [REM_W-1:0]    rem_next;
    logic [DIVD_W-1:0]   div_q;
    logic [SLEFT_W-1:0]  len_clamped;
    logic signed [16:0]  wave;
    logic signed [16:0]  left_sum;
    logic signed [16:0]  right_sum;

    assign s_accept  = s_valid && ctrl.s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign push_ok   = tone_count_reg != CNT_W'(TONE_DEPTH);
    assign pop_hz    = (tone_count_reg != '0) ? code_to_hz(rd_data_reg) : '0;

    // ---------------------------------------------------------------
    // APB register file
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= RATE_RESET;
            tone_period_reg <= PERIOD_RESET;
            amplitude_reg   <= AMP_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SAMPLE_RATE: sample_rate_reg <= pwdata[RATE_W-1:0];
                REG_TONE_PERIOD: tone_period_reg <= pwdata[PERIOD_W-1:0];
                REG_AMPLITUDE:   amplitude_reg   <= pwdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLE_RATE: prdata = 32'(sample_rate_reg);
            REG_TONE_PERIOD: prdata = 32'(tone_period_reg);
            REG_AMPLITUDE:   prdata = 32'(amplitude_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Queue storage: write on push, read the head every cycle
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == OP_PUSH && push_ok) begin
            tone_mem[tail_reg] <= s_tone_code;
        end
        rd_data_reg <= tone_mem[head_reg];
    end

    // ---------------------------------------------------------------
    // Serial arithmetic datapath
    // ---------------------------------------------------------------
    // Operands for the three multiply passes: phase*old_hz, rate*period, phase*hz.
    always_comb begin
        case (state_reg)
            ST_RS_MUL: begin
                mul_a = phase_reg;
                mul_b = old_hz_reg;
            end
            ST_LEN_MUL: begin
                mul_a = PHASE_W'(sample_rate_reg);
                mul_b = MULB_W'(tone_period_reg);
            end
            default: begin
                mul_a = phase_reg;
                mul_b = current_hz_reg;
            end
        endcase
    end

    // Multiplier bits MSB first, shift-and-add into the work register; the
    // first step of a pass starts from an empty product.
    assign mul_bit  = mul_b[MULB_IW'(MULB_W - 1) - step_reg[MULB_IW-1:0]];
    assign mul_next = ((step_reg == '0) ? '0 : {work_reg[DIVD_W-2:0], 1'b0}) +
                      (mul_bit ? DIVD_W'(mul_a) : '0);

    always_comb begin
        case (state_reg)
            ST_RS_DIV:  divisor = REM_W'(current_hz_reg);
            ST_LEN_DIV: divisor = MS_PER_SEC;
            default:    divisor = (sample_rate_reg == '0) ? REM_W'(1) : sample_rate_reg;
        endcase
    end

    // Restoring division, one quotient bit per cycle.
    assign div_trial = {rem_reg, work_reg[DIVD_W-1]};
    assign div_ge    = div_trial >= {1'b0, divisor};
    assign rem_next  = div_ge ? REM_W'(div_trial - {1'b0, divisor}) : div_trial[REM_W-1:0];
    assign div_q     = {work_reg[DIVD_W-2:0], div_ge};

    always_comb begin
        if (div_q[DIVD_W-1:SLEFT_W] != '0) begin
            len_clamped = SAMPLES_MAX;
        end else if (div_q[SLEFT_W-1:0] == '0) begin
            len_clamped = SLEFT_W'(1);
        end else begin
            len_clamped = div_q[SLEFT_W-1:0];
        end
    end

    // Wave and saturating mix.
    always_comb begin
        if (current_hz_reg == '0) begin
            wave = '0;
        end else if (wave_neg_reg) begin
            wave = -$signed({2'b00, amplitude_reg});
        end else begin
            wave = $signed({2'b00, amplitude_reg});
        end
        left_sum  = $signed({left_hold_reg[15], left_hold_reg}) + wave;
        right_sum = $signed({right_hold_reg[15], right_hold_reg}) + wave;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_opcode == OP_MIX) begin
                    if (samples_left_reg == '0) begin
                        state_next = ST_POP;
                    end else if (current_hz_reg != '0) begin
                        state_next = ST_WV_MUL;
                    end else begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_POP: begin
                state_next = (pop_hz != '0) ? ST_RS_MUL : ST_LEN_MUL;
            end
            ST_RS_MUL: begin
                if (ctrl.mul_last) state_next = ST_RS_DIV;
            end
            ST_RS_DIV: begin
                if (ctrl.div_last) state_next = ST_LEN_MUL;
            end
            ST_LEN_MUL: begin
                if (ctrl.mul_last) state_next = ST_LEN_DIV;
            end
            ST_LEN_DIV: begin
                if (ctrl.div_last) begin
                    state_next = (current_hz_reg != '0) ? ST_WV_MUL : ST_MIX;
                end
            end
            ST_WV_MUL: begin
                if (ctrl.mul_last) state_next = ST_WV_DIV;
            end
            ST_WV_DIV: begin
                if (ctrl.div_last) state_next = ST_MIX;
            end
            ST_MIX: begin
                if (ctrl.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.s_ready  = state_reg == ST_IDLE;
        ctrl.out_free = !m_valid_reg || m_ready;
        ctrl.mix_fire = (state_reg == ST_MIX) && ctrl.out_free;
        ctrl.mul_last = step_reg == STEP_W'(MULB_W - 1);
        ctrl.div_last = step_reg == STEP_W'(DIVD_W - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Queue pointers, tone state and the arithmetic unit. The step counter
    // returns to zero at the end of every pass, so each pass starts clean.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            tail_reg         <= '0;
            tone_count_reg   <= '0;
            current_hz_reg   <= '0;
            samples_left_reg <= '0;
            phase_reg        <= '0;
            step_reg         <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (s_opcode)
                            OP_PUSH: begin
                                if (push_ok) begin
                                    tail_reg <= (tail_reg == PTR_W'(TONE_DEPTH - 1)) ?
                                                '0 : tail_reg + PTR_W'(1);
                                    tone_count_reg <= tone_count_reg + CNT_W'(1);
                                end
                            end
                            OP_STOP: begin
                                head_reg       <= '0;
                                tail_reg       <= '0;
                                tone_count_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_POP: begin
                    // Advance the head only when a code is really taken.
                    if (tone_count_reg != '0) begin
                        head_reg <= (head_reg == PTR_W'(TONE_DEPTH - 1)) ?
                                    '0 : head_reg + PTR_W'(1);
                        tone_count_reg <= tone_count_reg - CNT_W'(1);
                    end
                    old_hz_reg     <= current_hz_reg;
                    current_hz_reg <= pop_hz;
                end
                ST_RS_MUL, ST_LEN_MUL, ST_WV_MUL: begin
                    if (ctrl.mul_last) begin
                        step_reg <= '0;
                        rem_reg  <= '0;
                        // The wave pass divides twice the product.
                        work_reg <= (state_reg == ST_WV_MUL) ?
                                    {mul_next[DIVD_W-2:0], 1'b0} : mul_next;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                        work_reg <= mul_next;
                    end
                end
                ST_RS_DIV, ST_LEN_DIV, ST_WV_DIV: begin
                    rem_reg  <= rem_next;
                    work_reg <= div_q;
                    if (ctrl.div_last) begin
                        step_reg <= '0;
                        unique case (state_reg)
                            ST_RS_DIV:  phase_reg        <= div_q[PHASE_W-1:0];
                            ST_LEN_DIV: samples_left_reg <= len_clamped;
                            default:    wave_neg_reg     <= div_q[0];
                        endcase
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_MIX: begin
                    if (ctrl.out_free) begin
                        samples_left_reg <= samples_left_reg - SLEFT_W'(1);
                        if (current_hz_reg != '0) begin
                            phase_reg <= phase_reg + PHASE_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the incoming sample for the length of the computation.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_hold_reg  <= s_left_in;
            right_hold_reg <= s_right_in;
        end
    end

    // ---------------------------------------------------------------
    // Output slot
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.mix_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mix_fire) begin
            left_out_reg  <= $signed(sat16(left_sum));
            right_out_reg <= $signed(sat16(right_sum));
            playing_reg   <= tone_count_reg != '0;
        end
    end

    assign s_ready     = ctrl.s_ready;
    assign m_valid     = m_valid_reg;
    assign m_left_out  = left_out_reg;
    assign m_right_out = right_out_reg;
    assign m_playing   = playing_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PCSTM_ASSERT(a_count_bound, tone_count_reg <= CNT_W'(TONE_DEPTH))
    `PCSTM_ASSERT(a_empty_aligned, (tone_count_reg == '0) |-> (head_reg == tail_reg))
    `PCSTM_ASSERT(a_mix_has_length, (state_reg == ST_MIX) |-> (samples_left_reg != '0))
    `PCSTM_ASSERT(a_result_from_mix, $rose(m_valid_reg) |-> $past(state_reg == ST_MIX))

endmodule

`default_nettype wire
